/* sv/dhti_pkg.sv */
// shared constants, types and a helper function for the double hash table insert block
// no dependencies
package dhti_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int KEY_BITS  = 31;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int PRIME_W   = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  // modulo unit: dividend padded to an even bit count, two bits retired per cycle
  localparam int DVD_W     = KEY_BITS + (KEY_BITS % 2);
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int IN_TDATA_W  = ((KEY_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_PRIME  = 1'd1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOFREE   = 2'd3
  } status_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [CNT_W-1:0]  divisor;
  } mod_req_t;

  // one restoring remainder step: shift in one dividend bit, subtract if it fits
  function automatic logic [CNT_W-1:0] mod_step(input logic [CNT_W-1:0] rem,
                                                input logic bit_in,
                                                input logic [CNT_W-1:0] divisor);
    logic [CNT_W-1:0] t;
    t = {rem[CNT_W-2:0], bit_in};
    if (t >= divisor) begin
      mod_step = t - divisor;
    end else begin
      mod_step = t;
    end
  endfunction

endpackage

/* sv/dhti_ram.sv */
// generic single-port ram with registered read
// no dependencies
module dhti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/dhti_mod.sv */
// iterative remainder unit, two dividend bits per cycle, shared by all modulo steps
// depends on dhti_pkg
module dhti_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dhti_pkg::mod_req_t        req,
  output logic                      done,
  output logic [dhti_pkg::CNT_W-1:0] rem
);
  import dhti_pkg::*;

  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  r1;

  assign r1 = mod_step(rem_r, dvd_r[DVD_W-1], div_r);

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = mod_step(r1, dvd_r[DVD_W-2], div_r);
      dvd_nxt = {dvd_r[DVD_W-3:0], 2'b00};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* sv/double_hash_table_insert.sv */
// top level of the double hash table insert block: sequencer, valid map, result register
// depends on dhti_pkg, dhti_mod, dhti_ram
//
// Inserts one 31-bit key per transaction into an open-addressed table with double hashing
// and returns one result (status, slot) per key. The block takes one key at a time:
// in_tready is high only while the sequencer is idle. A key runs three remainders on one
// shared two-bits-per-cycle modulo unit (home slot, key mod prime, step mod table size),
// then walks the table probe by probe, each probe one key-ram read and one compare, for
// up to slots_in_use probes. A full table is answered without any remainder. The valid
// map is cleared at reset, so no clearing pass is needed. A finished result waits in the
// output register while the next key is accepted.
module double_hash_table_insert (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dhti_pkg::IN_TDATA_W-1:0]   in_tdata,   // [30:0] key
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dhti_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [1:0] status, [7:2] slot
  input  logic                              cfg_we,
  input  logic [dhti_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dhti_pkg::CFG_W-1:0]        cfg_wdata
);
  import dhti_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOD  = 5'b00010,
    S_RD   = 5'b00100,
    S_CHK  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PH_HOME = 2'd0,
    PH_PMOD = 2'd1,
    PH_STEP = 2'd2
  } phase_t;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [CFG_W-1:0]    slots_cfg_r;
  logic [PRIME_W-1:0]  prime_cfg_r;
  logic [CNT_W-1:0]    n_eff;
  logic [PRIME_W-1:0]  p_eff;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [SLOT_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    probe_r, probe_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic [MAX_SLOTS-1:0] valid_r, valid_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  mod_req_t            mreq;
  logic                mdone;
  logic [CNT_W-1:0]    mrem;
  logic                ram_we;
  logic [KEY_BITS-1:0] ram_rdata;
  logic [CNT_W:0]      idx_sum;
  logic [CNT_W-1:0]    probe_inc;
  logic [PRIME_W-1:0]  step_raw;

  // clamp the table size and prime to their usable ranges
  always_comb begin
    if (slots_cfg_r < CFG_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (slots_cfg_r > CFG_W'(MAX_SLOTS)) begin
      n_eff = CNT_W'(MAX_SLOTS);
    end else begin
      n_eff = CNT_W'(slots_cfg_r);
    end
    p_eff = (prime_cfg_r == '0) ? PRIME_W'(1) : prime_cfg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_cfg_r <= CFG_W'(7);
      prime_cfg_r <= PRIME_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOTS_IN_USE: slots_cfg_r <= cfg_wdata;
        CFG_PROBE_PRIME:  prime_cfg_r <= cfg_wdata[PRIME_W-1:0];
        default: ;
      endcase
    end
  end

  dhti_mod u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .done (mdone),
    .rem  (mrem)
  );

  dhti_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(MAX_SLOTS)
  ) u_keys (
    .clk  (clk),
    .we   (ram_we),
    .addr (idx_r),
    .wdata(key_r),
    .rdata(ram_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign idx_sum   = (CNT_W + 1)'(idx_r) + (CNT_W + 1)'(step_r);
  assign probe_inc = probe_r + 1'b1;
  assign step_raw  = p_eff - mrem[PRIME_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    step_nxt       = step_r;
    probe_nxt      = probe_r;
    occ_nxt        = occ_r;
    valid_nxt      = valid_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    mreq           = '{start: 1'b0, dividend: '0, divisor: n_eff};
    ram_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          key_nxt = in_tdata[KEY_BITS-1:0];
          if (occ_r >= n_eff) begin
            res_status_nxt = ST_FULL;
            res_slot_nxt   = '0;
            state_nxt      = S_OUT;
          end else begin
            mreq.start    = 1'b1;
            mreq.dividend = DVD_W'(in_tdata[KEY_BITS-1:0]);
            mreq.divisor  = n_eff;
            phase_nxt     = PH_HOME;
            state_nxt     = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mdone) begin
          unique case (phase_r)
            PH_HOME: begin
              idx_nxt       = mrem[SLOT_W-1:0];
              mreq.start    = 1'b1;
              mreq.dividend = DVD_W'(key_r);
              mreq.divisor  = CNT_W'(p_eff);
              phase_nxt     = PH_PMOD;
            end
            PH_PMOD: begin
              mreq.start    = 1'b1;
              mreq.dividend = DVD_W'(step_raw);
              mreq.divisor  = n_eff;
              phase_nxt     = PH_STEP;
            end
            PH_STEP: begin
              step_nxt  = mrem[SLOT_W-1:0];
              probe_nxt = '0;
              state_nxt = S_RD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!valid_r[idx_r]) begin
          ram_we         = 1'b1;
          valid_nxt[idx_r] = 1'b1;
          occ_nxt        = occ_r + 1'b1;
          res_status_nxt = ST_INSERTED;
          res_slot_nxt   = idx_r;
          state_nxt      = S_OUT;
        end else if (ram_rdata == key_r) begin
          res_status_nxt = ST_PRESENT;
          res_slot_nxt   = idx_r;
          state_nxt      = S_OUT;
        end else if (probe_inc >= n_eff) begin
          res_status_nxt = ST_NOFREE;
          res_slot_nxt   = '0;
          state_nxt      = S_OUT;
        end else begin
          probe_nxt = probe_inc;
          // idx and step are both below n, so one subtract wraps the sum
          if (idx_sum >= (CNT_W + 1)'(n_eff)) begin
            idx_nxt = SLOT_W'(idx_sum - (CNT_W + 1)'(n_eff));
          end else begin
            idx_nxt = idx_sum[SLOT_W-1:0];
          end
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_slot_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_HOME;
      occ_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      occ_r       <= occ_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    step_r       <= step_nxt;
    probe_r      <= probe_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
